// ===== sv/utcz_pkg.sv =====
// Shared types, constants and the month-length lookup for the UTC zone/date adjust block.
// No dependencies; every other file but utcz_if imports this package.
`default_nettype none
package utcz_pkg;

	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_DEC = 4'd12;
	localparam logic [6:0] YEAR_LAST = 7'd99;
	localparam logic [6:0] YEAR_SPAN = 7'd100;
	localparam logic [6:0] HOURS_PER_DAY = 7'd24;
	localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

	// Stage 1 word: hour wrapped, month and year sanitised, day step pending
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [6:0] hundredths;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic       day_inc;
		logic       day_dec;
	} s1_word_t;

	// Stage 2 word: stage 1 plus the lengths of this and the previous month
	typedef struct packed {
		s1_word_t   base;
		logic [4:0] len_cur;
		logic [4:0] len_prev;
	} s2_word_t;

	// Stage 3 word: day and month final, year step pending
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [6:0] hundredths;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic       year_inc;
		logic       year_dec;
	} s3_word_t;

	// Result word
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [6:0] hundredths;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} out_word_t;

	// Days in a month (1..12); February takes the leap length when asked
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			MON_FEB:                                    len = leap ? FEB_LEAP_DAYS : 5'd28;
			default:                                    len = 5'd31;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== sv/utcz_if.sv =====
// Channel interfaces: timestamp input, adjusted result output and zone offset write.
// Depends on nothing; used by the top level and its environment.
`default_nettype none
interface utcz_in_if;
	logic       valid;
	logic       ready;
	logic [4:0] hour_in;
	logic [5:0] minute_in;
	logic [5:0] second_in;
	logic [6:0] hundredths_in;
	logic [4:0] day_in;
	logic [3:0] month_in;
	logic [6:0] year_in;

	modport source (output valid, hour_in, minute_in, second_in, hundredths_in,
		day_in, month_in, year_in, input ready);
	modport sink (input valid, hour_in, minute_in, second_in, hundredths_in,
		day_in, month_in, year_in, output ready);
endinterface

interface utcz_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] hour_out;
	logic [5:0] minute_out;
	logic [5:0] second_out;
	logic [6:0] hundredths_out;
	logic [4:0] day_out;
	logic [3:0] month_out;
	logic [6:0] year_out;

	modport source (output valid, hour_out, minute_out, second_out, hundredths_out,
		day_out, month_out, year_out, input ready);
	modport sink (input valid, hour_out, minute_out, second_out, hundredths_out,
		day_out, month_out, year_out, output ready);
endinterface

interface utcz_cfg_if;
	logic              valid;
	logic              ready;
	logic signed [4:0] zone_offset_hours;

	modport source (output valid, zone_offset_hours, input ready);
	modport sink (input valid, zone_offset_hours, output ready);
endinterface
`default_nettype wire

// ===== sv/utcz_shift.sv =====
// Stage 1: apply the zone offset to the hour, wrap it and note the day step.
// Depends on utcz_pkg.
`default_nettype none
module utcz_shift import utcz_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_i,
	input  wire logic signed [4:0] zone,
	input  wire logic [4:0]        hour,
	input  wire logic [5:0]        minute,
	input  wire logic [5:0]        second,
	input  wire logic [6:0]        hundredths,
	input  wire logic [4:0]        day,
	input  wire logic [3:0]        month,
	input  wire logic [6:0]        year,
	output logic                   valid_o,
	output s1_word_t               word_o
);

	logic     valid_s1;
	s1_word_t word_s1;
	s1_word_t word_d;
	logic [6:0] hsum;
	logic       hneg;
	logic       hover;

	// Add the offset in 7-bit two's complement and wrap once by a day
	always_comb begin
		hsum  = {2'b00, hour} + {{2{zone[4]}}, zone};
		hneg  = hsum[6];
		hover = !hsum[6] && (hsum >= HOURS_PER_DAY);

		word_d.minute     = minute;
		word_d.second     = second;
		word_d.hundredths = hundredths;
		word_d.day        = day;
		word_d.day_inc    = hover;
		word_d.day_dec    = hneg;
		if (hover) begin
			word_d.hour = 5'(hsum - HOURS_PER_DAY);
		end else if (hneg) begin
			word_d.hour = 5'(hsum + HOURS_PER_DAY);
		end else begin
			word_d.hour = hsum[4:0];
		end

		// Clamp the month code into January..December
		if (month < MON_JAN) begin
			word_d.month = MON_JAN;
		end else if (month > MON_DEC) begin
			word_d.month = MON_DEC;
		end else begin
			word_d.month = month;
		end

		// Fold a year code beyond the century back into 0..99
		if (year >= YEAR_SPAN) begin
			word_d.year = year - YEAR_SPAN;
		end else begin
			word_d.year = year;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_i) begin
			word_s1 <= word_d;
		end
	end

	assign valid_o = valid_s1;
	assign word_o  = word_s1;

endmodule
`default_nettype wire

// ===== sv/utcz_mlen.sv =====
// Stage 2: look up the length of the current and the previous month.
// Depends on utcz_pkg.
`default_nettype none
module utcz_mlen import utcz_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     valid_i,
	input  wire s1_word_t word_i,
	output logic          valid_o,
	output s2_word_t      word_o
);

	logic       valid_s2;
	s2_word_t   word_s2;
	logic       leap;
	logic [3:0] prev_month;

	// Leap year when the two-digit year is a multiple of four
	always_comb begin
		leap = (word_i.year[1:0] == 2'b00);
		if (word_i.month == MON_JAN) begin
			prev_month = MON_DEC;
		end else begin
			prev_month = word_i.month - 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_i) begin
			word_s2.base     <= word_i;
			word_s2.len_cur  <= month_len(word_i.month, leap);
			word_s2.len_prev <= month_len(prev_month, leap);
		end
	end

	assign valid_o = valid_s2;
	assign word_o  = word_s2;

endmodule
`default_nettype wire

// ===== sv/utcz_roll.sv =====
// Stage 3: step the day, roll it over the month ends and flag a year step.
// Depends on utcz_pkg.
`default_nettype none
module utcz_roll import utcz_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     valid_i,
	input  wire s2_word_t word_i,
	output logic          valid_o,
	output s3_word_t      word_o
);

	logic       valid_s3;
	s3_word_t   word_s3;
	s3_word_t   word_d;
	logic [6:0] dstep;
	logic       under;
	logic       over;

	always_comb begin
		// Stepped day in two's complement, range -1..32
		dstep = {2'b00, word_i.base.day} + {6'd0, word_i.base.day_inc}
			- {6'd0, word_i.base.day_dec};
		under = dstep[6] || (dstep == 7'd0);
		over  = !dstep[6] && (dstep > {2'b00, word_i.len_cur});

		word_d.hour       = word_i.base.hour;
		word_d.minute     = word_i.base.minute;
		word_d.second     = word_i.base.second;
		word_d.hundredths = word_i.base.hundredths;
		word_d.year       = word_i.base.year;
		word_d.year_inc   = 1'b0;
		word_d.year_dec   = 1'b0;
		word_d.day        = dstep[4:0];
		word_d.month      = word_i.base.month;

		// Past the month end: first of next month, December wraps to January
		if (over) begin
			word_d.day = 5'd1;
			if (word_i.base.month == MON_DEC) begin
				word_d.month    = MON_JAN;
				word_d.year_inc = 1'b1;
			end else begin
				word_d.month = word_i.base.month + 4'd1;
			end
		// Before the first: last day of the previous month
		end else if (under) begin
			word_d.day = word_i.len_prev;
			if (word_i.base.month == MON_JAN) begin
				word_d.month    = MON_DEC;
				word_d.year_dec = 1'b1;
			end else begin
				word_d.month = word_i.base.month - 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_i) begin
			word_s3 <= word_d;
		end
	end

	assign valid_o = valid_s3;
	assign word_o  = word_s3;

endmodule
`default_nettype wire

// ===== sv/utcz_year.sv =====
// Stage 4: apply the year step with wrap across the century; output register.
// Depends on utcz_pkg.
`default_nettype none
module utcz_year import utcz_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     valid_i,
	input  wire s3_word_t word_i,
	output logic          valid_o,
	output out_word_t     word_o
);

	logic      valid_s4;
	out_word_t word_s4;
	logic [6:0] year_d;

	// Advance or step back the year, 99 wraps to 0 and 0 back to 99
	always_comb begin
		if (word_i.year_inc) begin
			year_d = (word_i.year >= YEAR_LAST) ? 7'd0 : word_i.year + 7'd1;
		end else if (word_i.year_dec) begin
			year_d = (word_i.year == 7'd0) ? YEAR_LAST : word_i.year - 7'd1;
		end else begin
			year_d = word_i.year;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_i) begin
			word_s4.hour       <= word_i.hour;
			word_s4.minute     <= word_i.minute;
			word_s4.second     <= word_i.second;
			word_s4.hundredths <= word_i.hundredths;
			word_s4.day        <= word_i.day;
			word_s4.month      <= word_i.month;
			word_s4.year       <= year_d;
		end
	end

	assign valid_o = valid_s4;
	assign word_o  = word_s4;

endmodule
`default_nettype wire

// ===== sv/utc_time_zone_date_adjust_core.sv =====
// UTC to local time zone adjust with date rollover, top level.
// Channels: ts_in takes one UTC timestamp word (hour, minute, second,
// hundredths, day, month, two-digit year); ts_out gives the local time word;
// cfg writes the signed whole-hour zone offset (always ready).
// Pipeline: one register stage each for hour shift, month-length lookup, day/month
// rollover and year wrap.
// Throughput: one word per cycle; every stage holds one word and the
// pipeline takes a new word in each cycle that ts_out drains.
// Stall: when ts_out.ready is low the last stage holds its word; earlier
// stages keep filling any empty slot, and ts_in.ready drops only once all
// four stages are occupied. No word is lost or repeated.
// Reset: arst_n clears all valid bits and sets the zone offset to zero.
// Write the zone offset only while no word is in flight.
// Minute, second and hundredths pass through unaltered.
// Depends on utcz_pkg, utcz_if and the four stage modules.
`default_nettype none
module utc_time_zone_date_adjust_core import utcz_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	utcz_in_if.sink   ts_in,
	utcz_out_if.source ts_out,
	utcz_cfg_if.sink  cfg
);

	logic signed [4:0] zone_q;
	logic      en1, en2, en3, en4;
	logic      v1, v2, v3, v4;
	s1_word_t  w1;
	s2_word_t  w2;
	s3_word_t  w3;
	out_word_t w4;

	// Zone offset register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= 5'sd0;
		end else if (cfg.valid) begin
			zone_q <= cfg.zone_offset_hours;
		end
	end

	// Advance a stage when it is empty or the next one moves
	assign en4         = !v4 || ts_out.ready;
	assign en3         = !v3 || en4;
	assign en2         = !v2 || en3;
	assign en1         = !v1 || en2;
	assign ts_in.ready = en1;

	utcz_shift u_shift (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en1),
		.valid_i    (ts_in.valid),
		.zone       (zone_q),
		.hour       (ts_in.hour_in),
		.minute     (ts_in.minute_in),
		.second     (ts_in.second_in),
		.hundredths (ts_in.hundredths_in),
		.day        (ts_in.day_in),
		.month      (ts_in.month_in),
		.year       (ts_in.year_in),
		.valid_o    (v1),
		.word_o     (w1)
	);

	utcz_mlen u_mlen (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en2),
		.valid_i (v1),
		.word_i  (w1),
		.valid_o (v2),
		.word_o  (w2)
	);

	utcz_roll u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en3),
		.valid_i (v2),
		.word_i  (w2),
		.valid_o (v3),
		.word_o  (w3)
	);

	utcz_year u_year (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en4),
		.valid_i (v3),
		.word_i  (w3),
		.valid_o (v4),
		.word_o  (w4)
	);

	// Drive the result channel from the output stage
	assign ts_out.valid          = v4;
	assign ts_out.hour_out       = w4.hour;
	assign ts_out.minute_out     = w4.minute;
	assign ts_out.second_out     = w4.second;
	assign ts_out.hundredths_out = w4.hundredths;
	assign ts_out.day_out        = w4.day;
	assign ts_out.month_out      = w4.month;
	assign ts_out.year_out       = w4.year;

endmodule
`default_nettype wire

// ===== tb/utcz_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the zone/date adjust core: watches the three channels, predicts each
// local-time word from its own copy of the zone offset and compares field by field.
// Depends on utcz_pkg (result word and month codes) and the channel interfaces in utcz_if.
module utcz_checker import utcz_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	utcz_in_if   ts_in,
	utcz_out_if  ts_out,
	utcz_cfg_if  cfg,
	output int   fail_count,
	output int   pending,
	output int   checked
);

	localparam int REPORT_CAP = 20;
	localparam int JAN = int'(MON_JAN);
	localparam int FEB = int'(MON_FEB);
	localparam int DEC = int'(MON_DEC);
	localparam int LAST_YEAR = int'(YEAR_LAST);
	localparam int CENTURY = int'(YEAR_SPAN);
	localparam int DAY_HOURS = int'(HOURS_PER_DAY);
	localparam int LEAP_FEB = int'(FEB_LEAP_DAYS);
	localparam int MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	out_word_t         local_q[$];
	logic signed [4:0] zone_hours = '0;

	// Out-of-range month codes count as long months
	function automatic int days_in_month(input int month, input int year);
		if (month < JAN || month > DEC)
			return 31;
		if (month == FEB && year % 4 == 0)
			return LEAP_FEB;
		return MONTH_DAYS[month];
	endfunction

	// Shift the hour by the zone, then carry a day step through month and year
	function automatic out_word_t local_time(input logic [4:0] hour, input logic [5:0] minute,
			input logic [5:0] second, input logic [6:0] hundredths, input logic [4:0] day,
			input logic [3:0] month, input logic [6:0] year, input logic signed [4:0] zone);
		int        h, d, m, y, prev;
		out_word_t w;
		h = int'(hour) + int'(zone);
		d = int'(day);
		m = int'(month);
		y = int'(year);
		if (m < JAN)
			m = JAN;
		else if (m > DEC)
			m = DEC;
		if (y >= CENTURY)
			y -= CENTURY;

		if (h >= DAY_HOURS) begin
			h -= DAY_HOURS;
			d += 1;
		end else if (h < 0) begin
			h += DAY_HOURS;
			d -= 1;
		end

		// Past the month end: first of next month; day zero or less: last of previous month
		if (d > days_in_month(m, y)) begin
			d = 1;
			m += 1;
		end else if (d <= 0) begin
			prev = (m == JAN) ? DEC : m - 1;
			d = days_in_month(prev, y);
			m -= 1;
		end

		if (m > DEC) begin
			m = JAN;
			y += 1;
		end else if (m <= 0) begin
			m = DEC;
			y -= 1;
		end
		if (y >= CENTURY)
			y = 0;
		else if (y < 0)
			y = LAST_YEAR;

		w.hour = h[4:0];
		w.minute = minute;
		w.second = second;
		w.hundredths = hundredths;
		w.day = d[4:0];
		w.month = m[3:0];
		w.year = y[6:0];
		return w;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Retire results first, then log new stamps and offset writes
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			zone_hours = '0;
		end else begin
			if (ts_out.valid && ts_out.ready) begin
				if (local_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$display("%0t: unexpected word, expected none, got %0d:%0d %0d/%0d/%0d",
							$time, ts_out.hour_out, ts_out.minute_out, ts_out.day_out,
							ts_out.month_out, ts_out.year_out);
				end else begin
					want = local_q.pop_front();
					check_field("hour", want.hour, ts_out.hour_out);
					check_field("minute", want.minute, ts_out.minute_out);
					check_field("second", want.second, ts_out.second_out);
					check_field("hundredths", want.hundredths, ts_out.hundredths_out);
					check_field("day", want.day, ts_out.day_out);
					check_field("month", want.month, ts_out.month_out);
					check_field("year", want.year, ts_out.year_out);
					checked++;
				end
			end
			if (ts_in.valid && ts_in.ready)
				local_q.push_back(local_time(ts_in.hour_in, ts_in.minute_in, ts_in.second_in,
					ts_in.hundredths_in, ts_in.day_in, ts_in.month_in, ts_in.year_in,
					zone_hours));
			if (cfg.valid && cfg.ready)
				zone_hours = cfg.zone_offset_hours;
		end
		pending = local_q.size();
	end

endmodule

// ===== tb/utc_time_zone_date_adjust_core_test.sv =====
`timescale 1ns / 100ps
// Top of the zone/date adjust testbench: clock, reset, stimulus and verdict.
// Depends on utcz_pkg, utcz_if, the core under test and utcz_checker.
module utc_time_zone_date_adjust_core_test import utcz_pkg::*;;

	localparam int CYCLE_LIMIT = 200000;
	localparam int BLOCK_WORDS = 117;
	localparam int BLOCKS = 9;

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   cycles;
	int   zones_written;
	int   fail_count;
	int   pending;
	int   checked;
	int   zone_plan [BLOCKS] = '{-16, 15, -12, 14, 0, -5, 9, 0, 0};

	utcz_in_if  ts_in();
	utcz_out_if ts_out();
	utcz_cfg_if cfg();

	utc_time_zone_date_adjust_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.ts_in (ts_in),
		.ts_out(ts_out),
		.cfg   (cfg)
	);

	utcz_checker scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.ts_in     (ts_in),
		.ts_out    (ts_out),
		.cfg       (cfg),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	always #5 clk = ~clk;

	// Stall the result side at random
	always @(negedge clk) begin
		ts_out.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Give up on a hung pipeline
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words outstanding", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one timestamp word after a random gap and hold it until taken
	task automatic push_stamp(input int hour, input int minute, input int second,
			input int hundredths, input int day, input int month, input int year);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			ts_in.valid <= 1'b0;
			@(negedge clk);
		end
		ts_in.valid <= 1'b1;
		ts_in.hour_in <= 5'(hour);
		ts_in.minute_in <= 6'(minute);
		ts_in.second_in <= 6'(second);
		ts_in.hundredths_in <= 7'(hundredths);
		ts_in.day_in <= 5'(day);
		ts_in.month_in <= 4'(month);
		ts_in.year_in <= 7'(year);
		do @(posedge clk); while (!ts_in.ready);
	endtask

	// Mostly plausible dates biased to day and hour edges, some raw noise
	task automatic send_random_stamp();
		int hour, day;
		int year;
		int pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			push_stamp($urandom_range(31), $urandom_range(63), $urandom_range(63),
				$urandom_range(127), $urandom_range(31), $urandom_range(15), $urandom_range(127));
		end else begin
			if ($urandom_range(1))
				hour = $urandom_range(23);
			else
				hour = $urandom_range(1) ? $urandom_range(3) : $urandom_range(23, 20);
			pick = $urandom_range(9);
			if (pick < 3)
				day = 1;
			else if (pick < 6)
				day = $urandom_range(31, 28);
			else
				day = $urandom_range(27, 1);
			pick = $urandom_range(9);
			if (pick == 0)
				year = int'(YEAR_LAST);
			else if (pick == 1)
				year = 0;
			else
				year = $urandom_range(99);
			push_stamp(hour, $urandom_range(59), $urandom_range(59), $urandom_range(99),
				day, $urandom_range(int'(MON_DEC), int'(MON_JAN)), year);
		end
	endtask

	// Drop valid and wait for every outstanding word to come back
	task automatic drain();
		@(negedge clk);
		ts_in.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Write the zone offset with the pipeline empty
	task automatic set_zone(input int hours);
		drain();
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.zone_offset_hours <= 5'(hours);
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		zones_written++;
	endtask

	initial begin
		arst_n = 1'b0;
		src_idle_pct = 38;
		sink_idle_pct = 78;
		ts_in.valid = 1'b0;
		ts_in.hour_in = '0;
		ts_in.minute_in = '0;
		ts_in.second_in = '0;
		ts_in.hundredths_in = '0;
		ts_in.day_in = '0;
		ts_in.month_in = '0;
		ts_in.year_in = '0;
		cfg.valid = 1'b0;
		cfg.zone_offset_hours = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset offset: zero fields, all-ones fields, plain pass-through
		push_stamp(0, 0, 0, 0, 0, 0, 0);
		push_stamp(31, 63, 63, 127, 31, 15, 127);
		push_stamp(12, 34, 56, 78, 15, 6, 24);

		// Forward steps: year wrap, rollover at exactly 24, leap and short months
		set_zone(14);
		push_stamp(23, 59, 59, 99, 31, int'(MON_DEC), int'(YEAR_LAST));
		push_stamp(10, 0, 0, 0, 28, int'(MON_FEB), 23);
		push_stamp(10, 0, 0, 0, 29, int'(MON_FEB), 24);
		push_stamp(10, 0, 0, 0, 28, int'(MON_FEB), 24);
		push_stamp(20, 15, 30, 45, 30, 4, 10);

		// Backward steps: new year's day, leap and plain March, hour landing on 0
		set_zone(-12);
		push_stamp(5, 1, 2, 3, 1, int'(MON_JAN), 0);
		push_stamp(11, 0, 0, 0, 1, 3, 24);
		push_stamp(11, 0, 0, 0, 1, 3, 23);
		push_stamp(12, 0, 0, 0, 1, 5, 10);
		push_stamp(3, 0, 0, 0, 0, 7, 50);

		// Largest positive code, hour above 23
		set_zone(15);
		push_stamp(31, 0, 0, 0, 15, 6, 50);
		push_stamp(9, 0, 0, 0, 31, int'(MON_JAN), 1);

		// Largest negative code, a month code out of range, day zero and overlong
		set_zone(-16);
		push_stamp(0, 0, 0, 0, 1, 13, 5);
		push_stamp(15, 0, 0, 0, 1, int'(MON_FEB), 0);
		push_stamp(16, 0, 0, 0, 0, int'(MON_JAN), 0);
		push_stamp(16, 0, 0, 0, 31, 4, 100);

		// Random blocks, each under its planned offset; the idling pattern changes at blocks 3 and 6
		zone_plan[7] = $urandom_range(31) - 16;
		zone_plan[8] = $urandom_range(31) - 16;
		for (int blk = 0; blk < BLOCKS; blk++) begin
			if (blk == 3) begin
				src_idle_pct = 78;
				sink_idle_pct = 38;
			end else if (blk == 6) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			set_zone(zone_plan[blk]);
			repeat (BLOCK_WORDS) send_random_stamp();
		end

		drain();
		repeat (8) @(negedge clk);

		$display("Checked %0d local-time words under %0d zone offset settings,", checked,
			zones_written);
		$display("calendar edge cases first, then random stamps with bursty and steady flow.");
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d field mismatches or stray words", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/utcz_pkg.sv
sv/utcz_if.sv
sv/utcz_shift.sv
sv/utcz_mlen.sv
sv/utcz_roll.sv
sv/utcz_year.sv
sv/utc_time_zone_date_adjust_core.sv
tb/utcz_checker.sv
tb/utc_time_zone_date_adjust_core_test.sv
